### hdl/tcw_pkg.sv
// Package for the text console character writer.
// Holds field widths, reset values, mode and register codes, the sequencer
// states and the geometry struct. Depends on nothing.
package tcw_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 128;

  // Channel field widths.
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int CROW_W  = 5;
  localparam int CCOL_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  // Register widths and internal cursor widths.
  localparam int NR_W       = 6;
  localparam int NC_W       = 8;
  localparam int ROW_W      = 6;
  localparam int PROD_W     = NR_W + NC_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [NR_W-1:0]    RESET_ROWS   = 6'd25;
  localparam logic [NC_W-1:0]    RESET_COLS   = 8'd80;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd10;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0]  RETURN_CHAR  = 8'd13;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS   = 2'd0,
    CFG_NUM_COLS   = 2'd1,
    CFG_TEXT_COLOR = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PLAN,
    S_ADDR,
    S_SWEEP,
    S_CHAR,
    S_BLANK,
    S_RDATA,
    S_DONE
  } seq_state_t;

  // Screen geometry in use, already clamped to the store's limits.
  typedef struct packed {
    logic [NR_W-1:0] rows;
    logic [NC_W-1:0] cols;
  } geo_t;

endpackage

### hdl/tcw_in_if.sv
// Input channel of the console writer: valid, ready and one command item.
// Depends on tcw_pkg for the field widths.
interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_col;

  modport source (output valid, mode, char_code, read_row, read_col, input ready);
  modport sink (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

### hdl/tcw_out_if.sv
// Result channel of the console writer: valid, ready and one result item.
// Depends on tcw_pkg for the field widths.
interface tcw_out_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CROW_W-1:0]  cursor_row;
  logic [CCOL_W-1:0]  cursor_col;
  logic [CHAR_W-1:0]  cell_char;
  logic [COLOR_W-1:0] cell_color;
  logic               scrolled;

  modport source (output valid, cursor_row, cursor_col, cell_char, cell_color, scrolled,
                  input ready);
  modport sink (input valid, cursor_row, cursor_col, cell_char, cell_color, scrolled,
                output ready);
endinterface

### hdl/tcw_cfg_if.sv
// Configuration write channel of the console writer: register index and data.
// Depends on tcw_pkg for the field widths.
interface tcw_cfg_if;
  import tcw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface

### hdl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/tcw_cfg_regs.sv
// Configuration registers of the console writer and the clamped geometry.
// Depends on tcw_pkg and tcw_cfg_if.
module tcw_cfg_regs #(
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tcw_cfg_if.sink                       cfg_ch,
  output tcw_pkg::geo_t                 geo,
  output logic [tcw_pkg::COLOR_W-1:0]   text_color
);
  import tcw_pkg::*;

  logic [NR_W-1:0]    num_rows_r;
  logic [NC_W-1:0]    num_cols_r;
  logic [COLOR_W-1:0] text_color_r;

  assign cfg_ch.ready = 1'b1;

  // A write to an index past the list is taken and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r   <= RESET_ROWS;
      num_cols_r   <= RESET_COLS;
      text_color_r <= RESET_COLOR;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.idx))
        CFG_NUM_ROWS:   num_rows_r   <= cfg_ch.wdata[NR_W-1:0];
        CFG_NUM_COLS:   num_cols_r   <= cfg_ch.wdata[NC_W-1:0];
        CFG_TEXT_COLOR: text_color_r <= cfg_ch.wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_rows_r == '0) begin
      geo.rows = NR_W'(1);
    end else if (int'(num_rows_r) > MAX_ROWS) begin
      geo.rows = NR_W'(MAX_ROWS);
    end else begin
      geo.rows = num_rows_r;
    end
    if (num_cols_r == '0) begin
      geo.cols = NC_W'(1);
    end else if (int'(num_cols_r) > MAX_COLS) begin
      geo.cols = NC_W'(MAX_COLS);
    end else begin
      geo.cols = num_cols_r;
    end
  end

  assign text_color = text_color_r;

endmodule

### hdl/tcw_seq.sv
// Sequencer of the console writer: cursor, command decode, store sweeps
// (scroll, clear, power-up wipe) and the output register. Drives the cell RAM.
// Depends on tcw_pkg, tcw_in_if and tcw_out_if.
module tcw_seq #(
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  localparam int CELLS = MAX_ROWS * MAX_COLS,
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int CNT_W = $clog2(CELLS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tcw_in_if.sink                       in_ch,
  tcw_out_if.source                    out_ch,
  input  tcw_pkg::geo_t                geo,
  input  logic [tcw_pkg::COLOR_W-1:0]  text_color,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]   ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]   ram_rdata
);
  import tcw_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [AW-1:0]      init_addr_r, init_addr_nxt;
  mode_t              mode_r, mode_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic [RROW_W-1:0]  rrow_r, rrow_nxt;
  logic [RCOL_W-1:0]  rcol_r, rcol_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [CCOL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   nxt_row_r, nxt_row_nxt;
  logic [CCOL_W-1:0]  nxt_col_r, nxt_col_nxt;
  logic [ROW_W-1:0]   wr_row_r, wr_row_nxt;
  logic [CCOL_W-1:0]  wr_col_r, wr_col_nxt;
  logic               newline_r, newline_nxt;
  logic [1:0]         nscroll_r, nscroll_nxt;
  logic               scrolled_r, scrolled_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   move_end_r, move_end_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   sw_r, sw_nxt;
  logic               p_valid_r, p_valid_nxt;
  logic [AW-1:0]      p_addr_r, p_addr_nxt;
  logic               p_move_r, p_move_nxt;
  logic [CHAR_W-1:0]  cell_char_r, cell_char_nxt;
  logic [COLOR_W-1:0] cell_color_r, cell_color_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CROW_W-1:0]  o_row_r, o_row_nxt;
  logic [CCOL_W-1:0]  o_col_r, o_col_nxt;
  logic [CHAR_W-1:0]  o_char_r, o_char_nxt;
  logic [COLOR_W-1:0] o_color_r, o_color_nxt;
  logic               o_scr_r, o_scr_nxt;

  // Cursor planning, from the accepted item and the cursor at rest.
  logic [ROW_W:0]     rows_x;
  logic [ROW_W:0]     row1, row2, row3, row3c;
  logic [CCOL_W-1:0]  col1, col2;
  logic               wrap1, wrap2, is_nl;

  // One multiplier, shared: rows*cols while planning, row*cols for the address.
  logic [PROD_W-1:0]  mul_a, prod, sum;
  logic [CNT_W:0]     sweep_src;
  logic [CNT_W-1:0]   blank_idx;

  always_comb begin
    rows_x = {1'b0, geo.rows};
    if (cur_col_r >= geo.cols) begin
      row1 = {1'b0, cur_row_r} + (ROW_W+1)'(1);
      col1 = '0;
    end else begin
      row1 = {1'b0, cur_row_r};
      col1 = cur_col_r;
    end
    wrap1 = (row1 >= rows_x);
    row2  = wrap1 ? rows_x - (ROW_W+1)'(1) : row1;
    col2  = wrap1 ? '0 : col1;
    is_nl = (char_r == NEWLINE_CHAR) || (char_r == RETURN_CHAR);
    row3  = row2 + (ROW_W+1)'(1);
    wrap2 = (row3 >= rows_x);
    row3c = wrap2 ? rows_x - (ROW_W+1)'(1) : row3;
  end

  always_comb begin
    if (state_r == S_PLAN) begin
      mul_a = PROD_W'(geo.rows);
    end else if (mode_r == MODE_READ) begin
      mul_a = PROD_W'(rrow_r);
    end else begin
      mul_a = PROD_W'(wr_row_r);
    end
    prod = mul_a * PROD_W'(geo.cols);
    if (mode_r == MODE_READ) begin
      sum = prod + PROD_W'(rcol_r);
    end else begin
      sum = prod + PROD_W'(wr_col_r);
    end
  end

  assign sweep_src = {1'b0, sw_r} + (CNT_W+1)'(geo.cols);
  assign blank_idx = idx_r + CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    init_addr_nxt  = init_addr_r;
    mode_nxt       = mode_r;
    char_nxt       = char_r;
    rrow_nxt       = rrow_r;
    rcol_nxt       = rcol_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    nxt_row_nxt    = nxt_row_r;
    nxt_col_nxt    = nxt_col_r;
    wr_row_nxt     = wr_row_r;
    wr_col_nxt     = wr_col_r;
    newline_nxt    = newline_r;
    nscroll_nxt    = nscroll_r;
    scrolled_nxt   = scrolled_r;
    rd_ok_nxt      = rd_ok_r;
    total_nxt      = total_r;
    move_end_nxt   = move_end_r;
    idx_nxt        = idx_r;
    sw_nxt         = sw_r;
    p_valid_nxt    = 1'b0;
    p_addr_nxt     = p_addr_r;
    p_move_nxt     = p_move_r;
    cell_char_nxt  = cell_char_r;
    cell_color_nxt = cell_color_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_row_nxt      = o_row_r;
    o_col_nxt      = o_col_r;
    o_char_nxt     = o_char_r;
    o_color_nxt    = o_color_r;
    o_scr_nxt      = o_scr_r;
    in_ch.ready    = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    // The sweep writes in the cycle after its read; this port is free in every
    // other state while a sweep write is still in flight.
    if (p_valid_r) begin
      ram_we    = 1'b1;
      ram_waddr = p_addr_r;
      ram_wdata = p_move_r ? ram_rdata : '0;
    end

    case (state_r)
      S_INIT: begin
        ram_we        = 1'b1;
        ram_waddr     = init_addr_r;
        ram_wdata     = '0;
        init_addr_nxt = init_addr_r + AW'(1);
        if (init_addr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          mode_nxt  = mode_t'(in_ch.mode);
          char_nxt  = in_ch.char_code;
          rrow_nxt  = in_ch.read_row;
          rcol_nxt  = in_ch.read_col;
          state_nxt = S_PLAN;
        end
      end

      S_PLAN: begin
        total_nxt      = CNT_W'(prod);
        cell_char_nxt  = '0;
        cell_color_nxt = '0;
        scrolled_nxt   = 1'b0;
        nxt_row_nxt    = cur_row_r;
        nxt_col_nxt    = cur_col_r;
        rd_ok_nxt      = (NR_W'(rrow_r) < geo.rows) && (NC_W'(rcol_r) < geo.cols);
        newline_nxt    = is_nl;
        case (mode_r)
          MODE_PUT: begin
            if (is_nl) begin
              wr_row_nxt  = ROW_W'(row3c);
              wr_col_nxt  = '0;
              nxt_row_nxt = ROW_W'(row3c);
              nxt_col_nxt = '0;
              nscroll_nxt = {wrap1 && wrap2, wrap1 ^ wrap2};
            end else begin
              wr_row_nxt  = ROW_W'(row2);
              wr_col_nxt  = col2;
              nxt_row_nxt = ROW_W'(row2);
              nxt_col_nxt = col2 + CCOL_W'(1);
              nscroll_nxt = {1'b0, wrap1};
            end
            scrolled_nxt = wrap1 || (is_nl && wrap2);
            state_nxt    = S_ADDR;
          end
          MODE_READ: begin
            state_nxt = S_ADDR;
          end
          MODE_CLEAR: begin
            // A clear is one sweep that moves nothing.
            move_end_nxt = '0;
            sw_nxt       = '0;
            nscroll_nxt  = 2'd1;
            state_nxt    = S_SWEEP;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_ADDR: begin
        idx_nxt      = CNT_W'(sum);
        move_end_nxt = total_r - CNT_W'(geo.cols);
        sw_nxt       = '0;
        if (mode_r == MODE_READ) begin
          ram_raddr = AW'(sum);
          state_nxt = S_RDATA;
        end else if (nscroll_r != 2'd0) begin
          state_nxt = S_SWEEP;
        end else begin
          state_nxt = S_CHAR;
        end
      end

      S_SWEEP: begin
        if (sw_r < total_r) begin
          ram_raddr   = AW'(sweep_src);
          p_valid_nxt = 1'b1;
          p_addr_nxt  = AW'(sw_r);
          p_move_nxt  = (sw_r < move_end_r);
          sw_nxt      = sw_r + CNT_W'(1);
        end else if (!p_valid_r) begin
          nscroll_nxt = nscroll_r - 2'd1;
          sw_nxt      = '0;
          if (mode_r == MODE_CLEAR) begin
            state_nxt = S_DONE;
          end else if (nscroll_r == 2'd1) begin
            state_nxt = S_CHAR;
          end
        end
      end

      S_CHAR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        ram_wdata = {text_color, (newline_r ? CHAR_W'(0) : char_r)};
        state_nxt = newline_r ? S_DONE : S_BLANK;
      end

      S_BLANK: begin
        // The blank after the cursor is dropped past the end of the screen.
        if (blank_idx < total_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(blank_idx);
          ram_wdata = {text_color, CHAR_W'(0)};
        end
        state_nxt = S_DONE;
      end

      S_RDATA: begin
        if (rd_ok_r) begin
          cell_char_nxt  = ram_rdata[CHAR_W-1:0];
          cell_color_nxt = ram_rdata[CELL_W-1:CHAR_W];
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_row_nxt     = nxt_row_r[CROW_W-1:0];
          o_col_nxt     = nxt_col_r;
          o_char_nxt    = cell_char_r;
          o_color_nxt   = cell_color_r;
          o_scr_nxt     = scrolled_r;
          cur_row_nxt   = nxt_row_r;
          cur_col_nxt   = nxt_col_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_addr_r <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      nscroll_r   <= '0;
      sw_r        <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      nscroll_r   <= nscroll_nxt;
      sw_r        <= sw_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    char_r       <= char_nxt;
    rrow_r       <= rrow_nxt;
    rcol_r       <= rcol_nxt;
    nxt_row_r    <= nxt_row_nxt;
    nxt_col_r    <= nxt_col_nxt;
    wr_row_r     <= wr_row_nxt;
    wr_col_r     <= wr_col_nxt;
    newline_r    <= newline_nxt;
    scrolled_r   <= scrolled_nxt;
    rd_ok_r      <= rd_ok_nxt;
    total_r      <= total_nxt;
    move_end_r   <= move_end_nxt;
    idx_r        <= idx_nxt;
    p_addr_r     <= p_addr_nxt;
    p_move_r     <= p_move_nxt;
    cell_char_r  <= cell_char_nxt;
    cell_color_r <= cell_color_nxt;
    o_row_r      <= o_row_nxt;
    o_col_r      <= o_col_nxt;
    o_char_r     <= o_char_nxt;
    o_color_r    <= o_color_nxt;
    o_scr_r      <= o_scr_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_row = o_row_r;
  assign out_ch.cursor_col = o_col_r;
  assign out_ch.cell_char  = o_char_r;
  assign out_ch.cell_color = o_color_r;
  assign out_ch.scrolled   = o_scr_r;

endmodule

### hdl/text_console_char_writer_unit.sv
// Top level of the text console character writer.
// Depends on tcw_pkg, the three channel interfaces, tcw_cfg_regs, tcw_ram, tcw_seq.
//
//   channel  direction  transfer carries
//   in_ch    in         mode, char_code, read_row, read_col
//   out_ch   out        cursor_row, cursor_col, cell_char, cell_color, scrolled
//   cfg_ch   in         idx (0 num_rows, 1 num_cols, 2 text_color), wdata
//
// One item at a time. A put steps through plan, address, character, blank and
// done (a newline skips the blank); a read reads the cell, mode 3 only plans and a
// clear sweeps the screen once. Each scroll (at most two per put) sweeps rows*cols
// cells, one cell per cycle on the single RAM write port. The next input can be
// taken once the result is valid. After reset every cell is wiped before the
// first input transfer. A stalled output holds the next item in its last step.
module text_console_char_writer_unit #(
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch,
  tcw_cfg_if.sink    cfg_ch
);
  import tcw_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  geo_t               geo;
  logic [COLOR_W-1:0] text_color;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  tcw_cfg_regs #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .geo        (geo),
    .text_color (text_color)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .geo        (geo),
    .text_color (text_color),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

endmodule
